// ----- hdl/lttl_pkg.sv -----
// Shared types and constants for the lock-then-timed-load session controller.
package lttl_pkg;

    localparam int unsigned MINUTES_W  = 16;
    localparam int unsigned MS_W       = 32;
    localparam int unsigned S_TDATA_W  = 24;
    localparam int unsigned M_TDATA_W  = 8;
    localparam int unsigned CFG_IDX_W  = 1;

    localparam logic [MS_W-1:0] MS_PER_MINUTE      = 32'd60000;
    localparam logic [MS_W-1:0] LOCK_WAIT_RESET    = 32'd1200000;
    localparam logic [MS_W-1:0] RELEASE_WAIT_RESET = 32'd120000;
    localparam logic [MS_W-1:0] MS_MAX             = 32'hFFFF_FFFF;

    localparam logic [CFG_IDX_W-1:0] CFG_LOCK_WAIT    = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_RELEASE_WAIT = 1'b1;

    localparam logic ACT_TICK  = 1'b0;
    localparam logic ACT_START = 1'b1;

    localparam logic [1:0] PHASE_IDLE    = 2'd0;
    localparam logic [1:0] PHASE_LOCK    = 2'd1;
    localparam logic [1:0] PHASE_SESSION = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE    = 3'b001,
        ST_LOCK    = 3'b010,
        ST_SESSION = 3'b100
    } state_t;

    typedef struct packed {
        logic [MINUTES_W-1:0] session_minutes;
        logic                 action;
        logic                 locked;
        logic                 sense;
    } item_t;

    typedef struct packed {
        logic [1:0] phase;
        logic       green_lamp;
        logic       orange_lamp;
        logic       red_lamp;
        logic       load_out;
        logic       call_request;
        logic       lock_timed_out;
    } result_t;

endpackage

// ----- hdl/lttl_core.sv -----
// Session state, configuration registers and per-transaction next-state logic.
module lttl_core (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           item_accept,
    input  lttl_pkg::item_t                item,
    input  logic                           cfg_accept,
    input  logic [lttl_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [lttl_pkg::MS_W-1:0]      cfg_data,
    output lttl_pkg::result_t              result
);
    import lttl_pkg::*;

    state_t          phase_reg, phase_next;
    logic [MS_W-1:0] phase_ms_reg, phase_ms_next;
    logic [MS_W-1:0] release_ms_reg, release_ms_next;
    logic [MS_W-1:0] limit_ms_reg, limit_ms_next;
    logic            load_on_reg, load_on_next;
    logic [MS_W-1:0] lock_wait_reg;
    logic [MS_W-1:0] release_wait_reg;

    logic [MS_W-1:0] phase_inc;
    logic [MS_W-1:0] release_inc;
    logic [MS_W-1:0] limit_calc;
    logic            call;
    logic            timed_out;
    logic            sess_end;

    assign phase_inc   = (phase_ms_reg == MS_MAX) ? phase_ms_reg : phase_ms_reg + MS_W'(1);
    assign release_inc = (release_ms_reg == MS_MAX) ? release_ms_reg
                                                    : release_ms_reg + MS_W'(1);
    assign limit_calc  = MS_W'({16'd0, item.session_minutes} * MS_PER_MINUTE);

    always_comb begin
        phase_next      = phase_reg;
        phase_ms_next   = phase_ms_reg;
        release_ms_next = release_ms_reg;
        limit_ms_next   = limit_ms_reg;
        load_on_next    = load_on_reg;
        call            = 1'b0;
        timed_out       = 1'b0;
        sess_end        = 1'b0;
        if (item.action == ACT_START) begin
            if (phase_reg == ST_IDLE) begin
                phase_next      = ST_LOCK;
                phase_ms_next   = '0;
                release_ms_next = '0;
                limit_ms_next   = limit_calc;
                load_on_next    = 1'b0;
            end
        end else begin
            case (phase_reg)
                ST_IDLE: begin
                end
                ST_LOCK: begin
                    if (item.locked) begin
                        phase_next      = ST_SESSION;
                        phase_ms_next   = '0;
                        release_ms_next = '0;
                    end else begin
                        phase_ms_next = phase_inc;
                        if (phase_inc >= lock_wait_reg) begin
                            phase_next   = ST_IDLE;
                            load_on_next = 1'b0;
                            timed_out    = 1'b1;
                        end
                    end
                end
                ST_SESSION: begin
                    phase_ms_next   = phase_inc;
                    release_ms_next = release_inc;
                    if (phase_inc >= limit_ms_reg) begin
                        sess_end = 1'b1;
                    end else if (item.sense) begin
                        load_on_next = 1'b1;
                    end else begin
                        if (load_on_reg) begin
                            release_ms_next = '0;
                            load_on_next    = 1'b0;
                            // zero wait ends the session on the falling edge
                            if (release_wait_reg == '0) sess_end = 1'b1;
                        end else if (release_inc >= release_wait_reg) begin
                            sess_end = 1'b1;
                        end
                    end
                    if (sess_end) begin
                        phase_next   = ST_IDLE;
                        load_on_next = 1'b0;
                        call         = 1'b1;
                    end
                end
                default: begin
                    phase_next   = ST_IDLE;
                    load_on_next = 1'b0;
                end
            endcase
        end
    end

    always_comb begin
        case (phase_next)
            ST_LOCK:    result.phase = PHASE_LOCK;
            ST_SESSION: result.phase = PHASE_SESSION;
            default:    result.phase = PHASE_IDLE;
        endcase
        result.green_lamp     = (phase_next != ST_IDLE);
        result.orange_lamp    = (phase_next == ST_SESSION);
        result.red_lamp       = load_on_next;
        result.load_out       = load_on_next;
        result.call_request   = call;
        result.lock_timed_out = timed_out;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg        <= ST_IDLE;
            phase_ms_reg     <= '0;
            release_ms_reg   <= '0;
            limit_ms_reg     <= '0;
            load_on_reg      <= 1'b0;
            lock_wait_reg    <= LOCK_WAIT_RESET;
            release_wait_reg <= RELEASE_WAIT_RESET;
        end else begin
            if (item_accept) begin
                phase_reg      <= phase_next;
                phase_ms_reg   <= phase_ms_next;
                release_ms_reg <= release_ms_next;
                limit_ms_reg   <= limit_ms_next;
                load_on_reg    <= load_on_next;
            end
            if (cfg_accept) begin
                case (cfg_index)
                    CFG_LOCK_WAIT:    lock_wait_reg    <= cfg_data;
                    CFG_RELEASE_WAIT: release_wait_reg <= cfg_data;
                    default: begin
                    end
                endcase
            end
        end
    end

    a_load_in_session: assert property (@(posedge aclk) disable iff (!aresetn)
        load_on_reg |-> phase_reg == ST_SESSION)
        else $error("load on outside session");

    a_single_pulse: assert property (@(posedge aclk) disable iff (!aresetn)
        !(call && timed_out))
        else $error("call and lock timeout together");

    a_call_idles: assert property (@(posedge aclk) disable iff (!aresetn)
        item_accept && call |=> phase_reg == ST_IDLE && !load_on_reg)
        else $error("session end did not return to idle");

    a_start_enters_lock: assert property (@(posedge aclk) disable iff (!aresetn)
        item_accept && item.action == ACT_START && phase_reg == ST_IDLE
        |=> phase_reg == ST_LOCK && phase_ms_reg == '0)
        else $error("start did not enter lock wait");

endmodule

// ----- hdl/lttl_out.sv -----
// Output register stage for result transactions.
module lttl_out (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  lttl_pkg::result_t             in_result,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [lttl_pkg::M_TDATA_W-1:0] m_tdata
);
    import lttl_pkg::*;

    logic    valid_reg;
    result_t data_reg;

    assign in_ready = !valid_reg || m_tready;
    assign m_tvalid = valid_reg;
    assign m_tdata  = {data_reg.lock_timed_out, data_reg.call_request, data_reg.load_out,
                       data_reg.red_lamp, data_reg.orange_lamp, data_reg.green_lamp,
                       data_reg.phase};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            data_reg <= in_result;
        end
    end

endmodule

// ----- hdl/lock_then_timed_load_session.sv -----
// Top level of the lock-then-timed-load session controller.
//
//  channel   dir  handshake          payload
//  s_        in   s_tvalid/s_tready  s_tuser action; s_tdata minutes, locked, sense
//  m_        out  m_tvalid/m_tready  m_tdata phase, lamps, load, call, lock timeout
//  cfg_      in   cfg_valid/cfg_ready cfg_index, cfg_data (32-bit wait values)
//
// One transaction per cycle; each result appears in the cycle after its input.
// Throughput is set by the single output register: s_tready drops only while
// a held result is stalled by m_tready.
// aresetn is synchronous; it restores idle state and the default wait times.
// cfg_ready is always high.
module lock_then_timed_load_session (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // [15:0] session_minutes, [16] locked, [17] sense, [23:18] zero
    input  logic [lttl_pkg::S_TDATA_W-1:0] s_tdata,
    // [0] action
    input  logic                           s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // [1:0] phase, [2] green_lamp, [3] orange_lamp, [4] red_lamp, [5] load_out,
    // [6] call_request, [7] lock_timed_out
    output logic [lttl_pkg::M_TDATA_W-1:0] m_tdata,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [lttl_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [lttl_pkg::MS_W-1:0]      cfg_data
);
    import lttl_pkg::*;

    item_t   item;
    result_t result;
    logic    item_accept;

    assign item.session_minutes = s_tdata[MINUTES_W-1:0];
    assign item.locked          = s_tdata[MINUTES_W];
    assign item.sense           = s_tdata[MINUTES_W+1];
    assign item.action          = s_tuser;
    assign item_accept          = s_tvalid && s_tready;
    assign cfg_ready            = 1'b1;

    lttl_core u_core (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .item_accept (item_accept),
        .item        (item),
        .cfg_accept  (cfg_valid && cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .result      (result)
    );

    lttl_out u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_result (result),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule
